// ----- rtl/bfr_pkg.sv -----
// Shared types and constants for the flood replication engine.
package bfr_pkg;

    // Transaction kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_PACKET    = 2'd0,
        KIND_WR_IFACE  = 2'd1,
        KIND_WR_MEMBER = 2'd2,
        KIND_WR_BRIDGE = 2'd3
    } kind_t;

    // Output edge codes; the interface type code maps onto them one to one.
    typedef enum logic [1:0] {
        EDGE_PORT   = 2'd0,
        EDGE_BOND   = 2'd1,
        EDGE_BRIDGE = 2'd2,
        EDGE_DROP   = 2'd3
    } edge_t;

    localparam int IFW          = 6;
    localparam int PORTW        = 16;
    localparam int DOMW         = 4;
    localparam int CIW          = 6;
    localparam int RESULT_LIMIT = 64;

    typedef struct packed {
        kind_t             kind;
        logic [IFW-1:0]    iface_id;
        logic              iface_valid;
        logic              iface_up;
        logic [1:0]        iface_type;
        logic [PORTW-1:0]  iface_port;
        logic [DOMW-1:0]   iface_domain;
        logic [DOMW-1:0]   bridge_sel;
        logic [5:0]        member_slot;
        logic [IFW-1:0]    member_iface;
        logic              bridge_valid;
        logic [6:0]        member_count;
    } in_item_t;

    typedef struct packed {
        logic [IFW-1:0]    dest_iface;
        edge_t             next_edge;
        logic [PORTW-1:0]  out_port;
        logic              is_copy;
        logic [CIW-1:0]    copy_index;
        logic [DOMW-1:0]   domain_out;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              valid;
        logic              up;
        logic [1:0]        if_type;
        logic [PORTW-1:0]  port;
        logic [DOMW-1:0]   domain;
    } iface_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic hdr_read;
        logic walk_start;
        logic mem_step;
        logic take;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic bridge_ok;
        logic more;
        logic qualify;
        logic pend_valid;
        logic out_free;
        logic limit;
    } dp_status_t;

endpackage

// ----- rtl/bridge_flood_replicator.sv -----
// Top level of the layer-2 flood replication engine.
// Each copy descriptor is held as pending until the walk meets the next qualifying member or
// ends, so that the final one can be marked last; a drop-only descriptor is offered when the
// packet finishes with nothing pending. A packet occupies the block until its last descriptor
// enters the output register, output stalls included; a write transaction completes in the
// accepting cycle. After reset a clearing pass zeroes all tables and blocks the input.
module bridge_flood_replicator #(
    parameter int NUM_IFACES  = 64,
    parameter int NUM_BRIDGES = 16,
    parameter int MAX_MEMBERS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bfr_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bfr_pkg::out_item_t m_data
);
    import bfr_pkg::*;

    // The controller sequences each packet through source lookup, bridge header read and
    // the member walk; the datapath holds the three tables and the descriptor registers.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller accepts a transaction only when idle. Write transactions update the
    // tables in the accepting cycle; a packet starts the walk.
    bfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // One descriptor is held back as pending so that the final one of a packet can be
    // marked last once the walk knows no further member qualifies. The output register
    // decouples the walk from the result channel.
    bfr_datapath #(
        .NUM_IFACES  (NUM_IFACES),
        .NUM_BRIDGES (NUM_BRIDGES),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/bfr_ctrl.sv -----
// Sequencing state machine of the flood replication engine.
module bfr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  bfr_pkg::kind_t      s_kind,
    output logic                s_ready,
    input  bfr_pkg::dp_status_t status,
    output bfr_pkg::ctrl_cmd_t  cmd
);
    import bfr_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SRC    = 7'b0000100,
        ST_HDR    = 7'b0001000,
        ST_WMEM   = 7'b0010000,
        ST_WIFC   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_kind == KIND_PACKET) begin
                    state_next = ST_SRC;
                end
            end
            ST_SRC: begin
                cmd.hdr_read = 1'b1;
                state_next   = ST_HDR;
            end
            ST_HDR: begin
                if (status.bridge_ok) begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WMEM;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WMEM: begin
                cmd.mem_step = 1'b1;
                state_next   = ST_WIFC;
            end
            ST_WIFC: begin
                if (!status.qualify) begin
                    state_next = status.more ? ST_WMEM : ST_FINISH;
                end else if (!status.pend_valid || status.out_free) begin
                    cmd.take = 1'b1;
                    if (status.limit || !status.more) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_WMEM;
                    end
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/bfr_datapath.sv -----
// Tables, walk registers and output register of the flood replication engine.
module bfr_datapath #(
    parameter int NUM_IFACES  = 64,
    parameter int NUM_BRIDGES = 16,
    parameter int MAX_MEMBERS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bfr_pkg::in_item_t   s_data,
    input  bfr_pkg::ctrl_cmd_t  cmd,
    output bfr_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output bfr_pkg::out_item_t  m_data
);
    import bfr_pkg::*;

    localparam int IW    = $clog2(NUM_IFACES);
    localparam int BW    = (NUM_BRIDGES > 1) ? $clog2(NUM_BRIDGES) : 1;
    localparam int MD    = NUM_BRIDGES * MAX_MEMBERS;
    localparam int MAW   = $clog2(MD);
    localparam int CW    = $clog2(MAX_MEMBERS + 1);
    localparam int CLR_N = (MD > NUM_IFACES) ? MD : NUM_IFACES;
    localparam int CLRW  = $clog2(CLR_N);

    typedef struct packed {
        logic          valid;
        logic [CW-1:0] count;
    } hdr_entry_t;

    iface_entry_t   iface_mem  [NUM_IFACES];
    hdr_entry_t     hdr_mem    [NUM_BRIDGES];
    logic [IFW-1:0] member_mem [MD];

    logic [CLRW-1:0] clr_cnt_reg;
    iface_entry_t    ifc_rdata_reg;
    hdr_entry_t      hdr_rdata_reg;
    logic [IFW-1:0]  mem_rdata_reg;
    logic [IFW-1:0]  src_id_reg;
    logic            src_ok_reg;
    logic [DOMW-1:0] dom_reg;
    logic            dom_ok_reg;
    logic [MAW-1:0]  base_reg;
    logic [MAW-1:0]  maddr_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   slot_reg;
    logic            more_reg;
    logic [IFW-1:0]  cur_m_reg;
    logic            m_ok_reg;
    logic [CIW-1:0]  desc_cnt_reg;
    logic            pend_valid_reg;
    out_item_t       pend_reg;
    logic            m_valid_reg;
    out_item_t       m_data_reg;

    logic            src_read;
    logic            ifc_we;
    logic [IW-1:0]   ifc_waddr;
    iface_entry_t    ifc_wdata;
    logic            hdr_we;
    logic [BW-1:0]   hdr_waddr;
    hdr_entry_t      hdr_wdata;
    logic            mem_we;
    logic [MAW-1:0]  mem_waddr;
    logic [IFW-1:0]  mem_wdata;
    logic            ifc_re;
    logic [IW-1:0]   ifc_raddr;
    logic            mem_re;
    logic [MAW-1:0]  mem_raddr;
    logic [DOMW-1:0] dom_next;
    logic [CW-1:0]   slot_inc;
    logic            more_next;
    logic            qualify;
    out_item_t       new_desc;
    out_item_t       drop_desc;
    out_item_t       last_desc;
    logic            push;
    out_item_t       push_data;

    assign src_read = cmd.accept && (s_data.kind == KIND_PACKET);

    // Write ports: the clearing pass after reset, otherwise write transactions.
    always_comb begin
        ifc_we    = 1'b0;
        ifc_waddr = IW'(s_data.iface_id);
        ifc_wdata = '{valid:   s_data.iface_valid,
                      up:      s_data.iface_up,
                      if_type: s_data.iface_type,
                      port:    s_data.iface_port,
                      domain:  s_data.iface_domain};
        hdr_we    = 1'b0;
        hdr_waddr = BW'(s_data.bridge_sel);
        hdr_wdata.valid = s_data.bridge_valid;
        hdr_wdata.count = (32'(s_data.member_count) > MAX_MEMBERS) ?
                          CW'(MAX_MEMBERS) : CW'(s_data.member_count);
        mem_we    = 1'b0;
        mem_waddr = MAW'(s_data.bridge_sel) * MAW'(MAX_MEMBERS) + MAW'(s_data.member_slot);
        mem_wdata = s_data.member_iface;
        if (cmd.clear) begin
            ifc_we    = 32'(clr_cnt_reg) < NUM_IFACES;
            ifc_waddr = clr_cnt_reg[IW-1:0];
            ifc_wdata = '0;
            hdr_we    = 32'(clr_cnt_reg) < NUM_BRIDGES;
            hdr_waddr = clr_cnt_reg[BW-1:0];
            hdr_wdata = '0;
            mem_we    = 32'(clr_cnt_reg) < MD;
            mem_waddr = clr_cnt_reg[MAW-1:0];
            mem_wdata = '0;
        end else if (cmd.accept) begin
            ifc_we = (s_data.kind == KIND_WR_IFACE) && (32'(s_data.iface_id) < NUM_IFACES);
            hdr_we = (s_data.kind == KIND_WR_BRIDGE) &&
                     (32'(s_data.bridge_sel) < NUM_BRIDGES);
            mem_we = (s_data.kind == KIND_WR_MEMBER) &&
                     (32'(s_data.bridge_sel) < NUM_BRIDGES) &&
                     (32'(s_data.member_slot) < MAX_MEMBERS);
        end
    end

    always_ff @(posedge aclk) begin
        if (ifc_we) begin
            iface_mem[ifc_waddr] <= ifc_wdata;
        end
        if (hdr_we) begin
            hdr_mem[hdr_waddr] <= hdr_wdata;
        end
        if (mem_we) begin
            member_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Read ports.
    assign dom_next  = src_ok_reg ? ifc_rdata_reg.domain : '0;
    assign slot_inc  = slot_reg + CW'(1);
    assign more_next = slot_inc < cnt_reg;
    assign ifc_re    = src_read || cmd.mem_step;
    assign ifc_raddr = src_read ? IW'(s_data.iface_id) : IW'(mem_rdata_reg);
    assign mem_re    = cmd.walk_start || (cmd.mem_step && more_next);
    assign mem_raddr = cmd.walk_start ? base_reg : maddr_reg + MAW'(1);

    always_ff @(posedge aclk) begin
        if (ifc_re) begin
            ifc_rdata_reg <= iface_mem[ifc_raddr];
        end
        if (cmd.hdr_read) begin
            hdr_rdata_reg <= hdr_mem[BW'(dom_next)];
        end
        if (mem_re) begin
            mem_rdata_reg <= member_mem[mem_raddr];
        end
    end

    // Walk registers.
    always_ff @(posedge aclk) begin
        if (src_read) begin
            src_id_reg <= s_data.iface_id;
            src_ok_reg <= 32'(s_data.iface_id) < NUM_IFACES;
        end
        if (cmd.hdr_read) begin
            dom_reg    <= dom_next;
            dom_ok_reg <= 32'(dom_next) < NUM_BRIDGES;
            base_reg   <= MAW'(dom_next) * MAW'(MAX_MEMBERS);
        end
        if (cmd.walk_start) begin
            cnt_reg      <= hdr_rdata_reg.count;
            slot_reg     <= '0;
            maddr_reg    <= base_reg;
            desc_cnt_reg <= '0;
        end
        if (cmd.mem_step) begin
            cur_m_reg <= mem_rdata_reg;
            m_ok_reg  <= (32'(mem_rdata_reg) < NUM_IFACES) && (mem_rdata_reg != src_id_reg);
            slot_reg  <= slot_inc;
            more_reg  <= more_next;
            if (more_next) begin
                maddr_reg <= maddr_reg + MAW'(1);
            end
        end
        if (cmd.take) begin
            pend_reg     <= new_desc;
            desc_cnt_reg <= desc_cnt_reg + CIW'(1);
        end
    end

    assign qualify = m_ok_reg && ifc_rdata_reg.valid && ifc_rdata_reg.up;

    always_comb begin
        new_desc.dest_iface = cur_m_reg;
        new_desc.next_edge  = edge_t'(ifc_rdata_reg.if_type);
        new_desc.out_port   = (ifc_rdata_reg.if_type == EDGE_PORT) ? ifc_rdata_reg.port : '0;
        new_desc.is_copy    = desc_cnt_reg != '0;
        new_desc.copy_index = desc_cnt_reg;
        new_desc.domain_out = dom_reg;
        new_desc.last       = 1'b0;

        drop_desc.dest_iface = src_id_reg;
        drop_desc.next_edge  = EDGE_DROP;
        drop_desc.out_port   = '0;
        drop_desc.is_copy    = 1'b0;
        drop_desc.copy_index = '0;
        drop_desc.domain_out = dom_reg;
        drop_desc.last       = 1'b1;

        last_desc      = pend_reg;
        last_desc.last = 1'b1;

        push      = (cmd.take && pend_valid_reg) || cmd.finish;
        push_data = pend_reg;
        if (cmd.finish) begin
            push_data = pend_valid_reg ? last_desc : drop_desc;
        end
    end

    // Control state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + CLRW'(1);
            end
            if (src_read) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.take) begin
                pend_valid_reg <= 1'b1;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_data_reg <= push_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.clear_done = clr_cnt_reg == CLRW'(CLR_N - 1);
    assign status.bridge_ok  = dom_ok_reg && hdr_rdata_reg.valid && (hdr_rdata_reg.count != '0);
    assign status.more       = more_reg;
    assign status.qualify    = qualify;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.limit      = desc_cnt_reg == CIW'(RESULT_LIMIT - 1);

endmodule

// ----- tb/bridge_flood_replicator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the layer-2 flood replication engine.
module bridge_flood_replicator_tb;
    import bfr_pkg::*;

    // The block is built with its default sizes; the shadow tables use the same ones.
    localparam int NUM_IFACES   = 64;
    localparam int NUM_BRIDGES  = 16;
    localparam int MAX_MEMBERS  = 64;
    // The final pause is sized to cover one full walk of the longest member list with some margin.
    localparam int DRAIN_CYCLES = 4 + 2 * MAX_MEMBERS + 32;
    // The watchdog limit, in nanoseconds, is meant to allow several times the slowest legal run.
    localparam int TIMEOUT_NS   = 5_000_000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Percentages of cycles in which the sender holds back and the receiver refuses.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int items_sent     = 0;
    int packets_sent   = 0;
    int copies_checked = 0;
    int mismatches     = 0;

    // Shadow copy of the forwarding state, updated in the order transactions are accepted.
    iface_entry_t   shadow_iface  [NUM_IFACES]               = '{default: '0};
    logic           shadow_br_ok  [NUM_BRIDGES]              = '{default: 1'b0};
    int             shadow_br_cnt [NUM_BRIDGES]              = '{default: 0};
    logic [IFW-1:0] shadow_member [NUM_BRIDGES * MAX_MEMBERS] = '{default: '0};

    // Copy descriptors still owed by the block, oldest first.
    out_item_t expected_copies[$];

    bridge_flood_replicator #(
        .NUM_IFACES  (NUM_IFACES),
        .NUM_BRIDGES (NUM_BRIDGES),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial forever #2 aclk = ~aclk;

    // Applies one accepted transaction to the shadow state. Write transactions only update
    // the tables; a packet walks its bridge's member list and queues the descriptors that
    // the block must produce for it.
    function automatic void predict_flood(input in_item_t t);
        out_item_t       burst [RESULT_LIMIT];
        iface_entry_t    entry;
        logic [DOMW-1:0] dom;
        logic [IFW-1:0]  member;
        int              n;
        int              cnt;
        n = 0;
        case (t.kind)
            KIND_WR_IFACE: begin
                if (int'(t.iface_id) < NUM_IFACES) begin
                    shadow_iface[t.iface_id].valid   = t.iface_valid;
                    shadow_iface[t.iface_id].up      = t.iface_up;
                    shadow_iface[t.iface_id].if_type = t.iface_type;
                    shadow_iface[t.iface_id].port    = t.iface_port;
                    shadow_iface[t.iface_id].domain  = t.iface_domain;
                end
            end
            KIND_WR_MEMBER: begin
                if (int'(t.bridge_sel) < NUM_BRIDGES && int'(t.member_slot) < MAX_MEMBERS)
                    shadow_member[int'(t.bridge_sel) * MAX_MEMBERS + int'(t.member_slot)] =
                        t.member_iface;
            end
            KIND_WR_BRIDGE: begin
                // Counts beyond the list size are clipped when the header is stored.
                if (int'(t.bridge_sel) < NUM_BRIDGES) begin
                    shadow_br_ok[t.bridge_sel]  = t.bridge_valid;
                    shadow_br_cnt[t.bridge_sel] = (int'(t.member_count) > MAX_MEMBERS) ?
                                                  MAX_MEMBERS : int'(t.member_count);
                end
            end
            default: begin
                // The source's stored domain is used even when its entry is invalid.
                dom = (int'(t.iface_id) < NUM_IFACES) ? shadow_iface[t.iface_id].domain : '0;
                if (int'(dom) < NUM_BRIDGES && shadow_br_ok[dom]) begin
                    cnt = shadow_br_cnt[dom];
                    for (int s = 0; s < cnt && n < RESULT_LIMIT; s++) begin
                        member = shadow_member[int'(dom) * MAX_MEMBERS + s];
                        if (member == t.iface_id || int'(member) >= NUM_IFACES)
                            continue;
                        entry = shadow_iface[member];
                        if (!entry.valid || !entry.up)
                            continue;
                        // Interface type codes line up with the output edge codes.
                        burst[n].dest_iface = member;
                        burst[n].next_edge  = edge_t'(entry.if_type);
                        burst[n].out_port   = (burst[n].next_edge == EDGE_PORT) ? entry.port : '0;
                        burst[n].is_copy    = (n != 0);
                        burst[n].copy_index = n[CIW-1:0];
                        burst[n].domain_out = dom;
                        burst[n].last       = 1'b0;
                        n++;
                    end
                end
                // Nothing qualified, or the bridge does not exist: the source is dropped.
                if (n == 0) begin
                    burst[0].dest_iface = t.iface_id;
                    burst[0].next_edge  = EDGE_DROP;
                    burst[0].out_port   = '0;
                    burst[0].is_copy    = 1'b0;
                    burst[0].copy_index = '0;
                    burst[0].domain_out = dom;
                    burst[0].last       = 1'b0;
                    n = 1;
                end
                burst[n-1].last = 1'b1;
                for (int k = 0; k < n; k++)
                    expected_copies.push_back(burst[k]);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compares one delivered descriptor with the oldest one still owed.
    function automatic void check_descriptor(input out_item_t got);
        out_item_t want;
        if (expected_copies.size() == 0) begin
            $error("descriptor for interface %0d arrived with none outstanding",
                   got.dest_iface);
            mismatches++;
            return;
        end
        want = expected_copies.pop_front();
        check_field("dest_iface", 32'(want.dest_iface), 32'(got.dest_iface));
        check_field("next_edge",  32'(want.next_edge),  32'(got.next_edge));
        check_field("out_port",   32'(want.out_port),   32'(got.out_port));
        check_field("is_copy",    32'(want.is_copy),    32'(got.is_copy));
        check_field("copy_index", 32'(want.copy_index), 32'(got.copy_index));
        check_field("domain_out", 32'(want.domain_out), 32'(got.domain_out));
        check_field("last",       32'(want.last),       32'(got.last));
        copies_checked++;
    endfunction

    // The receiver: every edge it samples the handshake with the ready that was driven
    // beforehand, then draws a fresh ready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_descriptor(m_data);
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Transaction builders. Every one starts from random bits so that the fields a given
    // kind ignores still see both values of every bit.
    function automatic in_item_t noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t packet_item(input logic [IFW-1:0] src);
        in_item_t t;
        t          = noise_item();
        t.kind     = KIND_PACKET;
        t.iface_id = src;
        return t;
    endfunction

    function automatic in_item_t iface_write(input logic [IFW-1:0] id, input logic vld,
                                             input logic up, input edge_t typ,
                                             input logic [PORTW-1:0] port,
                                             input logic [DOMW-1:0] dom);
        in_item_t t;
        t              = noise_item();
        t.kind         = KIND_WR_IFACE;
        t.iface_id     = id;
        t.iface_valid  = vld;
        t.iface_up     = up;
        t.iface_type   = typ;
        t.iface_port   = port;
        t.iface_domain = dom;
        return t;
    endfunction

    function automatic in_item_t member_write(input logic [DOMW-1:0] br,
                                              input logic [5:0] slot,
                                              input logic [IFW-1:0] member);
        in_item_t t;
        t              = noise_item();
        t.kind         = KIND_WR_MEMBER;
        t.bridge_sel   = br;
        t.member_slot  = slot;
        t.member_iface = member;
        return t;
    endfunction

    function automatic in_item_t bridge_write(input logic [DOMW-1:0] br, input logic vld,
                                              input logic [6:0] count);
        in_item_t t;
        t              = noise_item();
        t.kind         = KIND_WR_BRIDGE;
        t.bridge_sel   = br;
        t.bridge_valid = vld;
        t.member_count = count;
        return t;
    endfunction

    // Offers one transaction and returns at the edge where it is accepted. Valid is only
    // lowered when the sender decides to idle, so back-to-back transactions keep it high.
    task automatic send_item(input in_item_t t);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_flood(t);
        items_sent++;
        if (t.kind == KIND_PACKET)
            packets_sent++;
    endtask

    // With every table cleared, any packet is dropped in domain zero.
    task automatic test_reset_state();
        send_item(packet_item(6'd63));
        send_item(packet_item(6'd0));
    endtask

    // Bridge 15 keeps its cleared member list, so all 64 slots name interface 0. With the
    // header count written beyond the list size it saturates, and a packet from an invalid
    // source in that domain fans out to exactly the descriptor limit. Once interface 0
    // itself joins the domain, every member is the source and the packet is dropped.
    task automatic test_descriptor_limit();
        send_item(iface_write(6'd0, 1'b1, 1'b1, EDGE_PORT, 16'hFFFF, 4'd0));
        send_item(iface_write(6'd1, 1'b0, 1'b0, EDGE_DROP, 16'h0000, 4'd15));
        send_item(bridge_write(4'd15, 1'b1, 7'd127));
        send_item(packet_item(6'd1));
        send_item(packet_item(6'd0));
        send_item(iface_write(6'd0, 1'b1, 1'b1, EDGE_PORT, 16'hFFFF, 4'd15));
        send_item(packet_item(6'd0));
    endtask

    // One member of each type, a member that is down, one never written (so invalid) and
    // the source itself, all in bridge 3. Only port members carry a port number.
    task automatic test_edge_kinds();
        send_item(iface_write(6'd11, 1'b1, 1'b1, EDGE_BOND,   16'h1234, 4'd0));
        send_item(iface_write(6'd12, 1'b1, 1'b1, EDGE_BRIDGE, 16'hABCD, 4'd9));
        send_item(iface_write(6'd13, 1'b1, 1'b1, EDGE_DROP,   16'h5555, 4'd2));
        send_item(iface_write(6'd14, 1'b1, 1'b0, EDGE_PORT,   16'h00FF, 4'd3));
        send_item(iface_write(6'd20, 1'b1, 1'b1, EDGE_PORT,   16'h0001, 4'd3));
        send_item(member_write(4'd3, 6'd0, 6'd0));
        send_item(member_write(4'd3, 6'd1, 6'd11));
        send_item(member_write(4'd3, 6'd2, 6'd12));
        send_item(member_write(4'd3, 6'd3, 6'd13));
        send_item(member_write(4'd3, 6'd4, 6'd14));
        send_item(member_write(4'd3, 6'd5, 6'd15));
        send_item(member_write(4'd3, 6'd6, 6'd20));
        send_item(bridge_write(4'd3, 1'b1, 7'd7));
        send_item(packet_item(6'd20));
    endtask

    // A valid bridge with an empty list, then an invalid bridge with members: both drop.
    task automatic test_empty_bridge();
        send_item(bridge_write(4'd3, 1'b1, 7'd0));
        send_item(packet_item(6'd20));
        send_item(bridge_write(4'd3, 1'b0, 7'd7));
        send_item(packet_item(6'd20));
    endtask

    // One well-formed session: populate part of a bridge's list and the entries it names,
    // place a source in the bridge's domain, publish the header, then flood a few packets.
    // Most counts are short; a few span the whole list or overflow it. Only a handful of
    // slots are rewritten each time, the rest keep what earlier sessions left there.
    task automatic random_bridge_session();
        logic [DOMW-1:0] br;
        logic [IFW-1:0]  src;
        logic [IFW-1:0]  member;
        logic [5:0]      slot;
        logic [6:0]      count;
        int              span;
        int              roll;
        br   = DOMW'($urandom_range(0, NUM_BRIDGES - 1));
        src  = IFW'($urandom_range(0, NUM_IFACES - 1));
        roll = $urandom_range(0, 99);
        if (roll < 65)
            count = 7'($urandom_range(1, 8));
        else if (roll < 82)
            count = 7'($urandom_range(9, 64));
        else if (roll < 94)
            count = 7'($urandom_range(65, 127));
        else
            count = '0;
        span = (int'(count) > MAX_MEMBERS) ? MAX_MEMBERS : int'(count);
        repeat ($urandom_range(1, 6)) begin
            member = ($urandom_range(0, 99) < 20) ?
                     src : IFW'($urandom_range(0, NUM_IFACES - 1));
            slot   = (span > 0 && $urandom_range(0, 99) < 90) ?
                     6'($urandom_range(0, span - 1)) : 6'($urandom_range(0, MAX_MEMBERS - 1));
            send_item(member_write(br, slot, member));
            if (member != src && $urandom_range(0, 99) < 70)
                send_item(iface_write(member, $urandom_range(0, 99) < 85,
                                      $urandom_range(0, 99) < 85,
                                      edge_t'($urandom_range(0, 3)),
                                      PORTW'($urandom_range(0, 65535)),
                                      DOMW'($urandom_range(0, 15))));
        end
        send_item(iface_write(src, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              edge_t'($urandom_range(0, 3)),
                              PORTW'($urandom_range(0, 65535)), br));
        send_item(bridge_write(br, $urandom_range(0, 99) < 90, count));
        repeat ($urandom_range(1, 4)) begin
            send_item(packet_item(($urandom_range(0, 99) < 80) ?
                                  src : IFW'($urandom_range(0, NUM_IFACES - 1))));
            if ($urandom_range(0, 99) < 10)
                send_item(noise_item());
        end
    endtask

    // Random traffic in four phases: no back-pressure, a sparse sender, a slow receiver,
    // and light idling on both sides.
    task automatic test_random_traffic(input int budget);
        int goal;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 82;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 82;
                end
                default: begin
                    src_idle_pct   = 20;
                    sink_stall_pct = 20;
                end
            endcase
            goal = items_sent + budget / 4;
            while (items_sent < goal)
                random_bridge_session();
        end
    endtask

    initial begin
        // Synchronous reset held low at the start; the block then clears its tables and
        // refuses transactions until it has finished, which the handshake absorbs.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_descriptor_limit();
        test_edge_kinds();
        test_empty_bridge();
        test_random_traffic(300);
        s_valid <= 1'b0;

        // Wait for every owed descriptor, then give the block time to show any extra ones.
        while (expected_copies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d transactions, %0d of them packets, under four pressure phases.",
                 items_sent, packets_sent);
        $display("Checked %0d copy descriptors field by field.", copies_checked);
        if (mismatches == 0)
            $display("[bridge_flood_replicator] OK");
        else
            $display("[bridge_flood_replicator] ERROR");
        $finish;
    end

    // Watchdog: a hung handshake or a descriptor that never arrives ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d descriptors still outstanding.", expected_copies.size());
        $display("[bridge_flood_replicator] ERROR");
        $finish;
    end

endmodule
